// ===== src/can_tx_frame_queue_assert.svh =====
// assertion macros for the can transmit frame queue
// included by the controller and datapath files, no other dependencies
`ifndef CAN_TX_FRAME_QUEUE_ASSERT_SVH
`define CAN_TX_FRAME_QUEUE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CTFQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CTFQ_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define CTFQ_ASSERT(label, clk, rst, prop, msg)
`define CTFQ_NEVER(label, clk, rst, expr, msg)
`endif

`endif

// ===== src/ctfq_pkg.sv =====
// types, constants and helper functions for the can transmit frame queue
// no dependencies; used by the controller, datapath and top level files
package ctfq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int DATA_W   = 64;
  localparam int ID_W     = 29;
  localparam int STD_ID_W = 11;
  localparam int LEN_W    = 4;
  localparam int CNT_W    = 16;
  localparam int BYTES    = DATA_W / 8;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(BYTES);

  localparam logic [1:0] CMD_ENQ_STD = 2'd0;
  localparam logic [1:0] CMD_ENQ_EXT = 2'd1;
  localparam logic [1:0] CMD_SERVICE = 2'd2;

  typedef struct packed {
    logic [1:0]        command;
    logic [ID_W-1:0]   frame_id;
    logic [LEN_W-1:0]  frame_length;
    logic [DATA_W-1:0] frame_data;
    logic              tx_complete;
    logic              bus_off;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    logic              tx_start;
    logic [ID_W-1:0]   tx_id;
    logic              tx_extended;
    logic [LEN_W-1:0]  tx_length;
    logic [DATA_W-1:0] tx_data;
    logic              reinit_request;
    logic [CNT_W-1:0]  overflow_total;
  } out_item_t;

  typedef struct packed {
    logic              extended;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  length;
    logic [DATA_W-1:0] data;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic push;
    logic flush;
    logic pop;
    logic load_now;
    logic load_mem;
    logic reinit;
  } ctl_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ctl_status_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    return (len > MAX_LEN) ? MAX_LEN : len;
  endfunction

  function automatic logic [DATA_W-1:0] keep_bytes(input logic [DATA_W-1:0] data,
                                                   input logic [LEN_W-1:0] len);
    logic [DATA_W-1:0] res;
    for (int b = 0; b < BYTES; b++) begin
      res[8*b +: 8] = (len > LEN_W'(b)) ? data[8*b +: 8] : 8'h00;
    end
    return res;
  endfunction

endpackage

// ===== src/ctfq_stream_if.sv =====
// valid/ready channel carrying one payload beat
// payload type is set per instance; no package dependency
interface ctfq_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== src/ctfq_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module ctfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/ctfq_dp.sv =====
// datapath: ring pointers, overflow counter, frame ram and result register
// depends on ctfq_pkg, ctfq_ram and the assertion macro header
`include "can_tx_frame_queue_assert.svh"

module ctfq_dp #(
  parameter int QUEUE_DEPTH = ctfq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctfq_pkg::ctl_cmd_t    cmd,
  input  ctfq_pkg::in_item_t    item,
  output ctfq_pkg::ctl_status_t status,
  output ctfq_pkg::out_item_t   res
);
  import ctfq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int PTR_W = IDX_W + 1;

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] overflow;
  logic [CNT_W-1:0] overflow_next;
  logic             pend_reinit;
  slot_t            wslot;
  slot_t            rslot;
  logic [LEN_W-1:0] len_clamped;

  assign status.empty = (wr_ptr == rd_ptr);
  assign status.full  = (wr_ptr[IDX_W] != rd_ptr[IDX_W]) &&
                        (wr_ptr[IDX_W-1:0] == rd_ptr[IDX_W-1:0]);

  assign len_clamped    = clamp_len(item.frame_length);
  assign wslot.extended = (item.command == CMD_ENQ_EXT);
  assign wslot.id       = wslot.extended ? item.frame_id
                                         : {{(ID_W-STD_ID_W){1'b0}}, item.frame_id[STD_ID_W-1:0]};
  assign wslot.length   = len_clamped;
  assign wslot.data     = keep_bytes(item.frame_data, len_clamped);

  ctfq_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.push),
    .waddr(wr_ptr[IDX_W-1:0]),
    .wdata(wslot),
    .re   (cmd.pop),
    .raddr(rd_ptr[IDX_W-1:0]),
    .rdata(rslot)
  );

  assign overflow_next = (cmd.flush && overflow != '1) ? overflow + 1'b1 : overflow;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      overflow <= '0;
    end else begin
      overflow <= overflow_next;
      if (cmd.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (cmd.flush) begin
        rd_ptr <= wr_ptr;
      end else if (cmd.pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      pend_reinit <= cmd.reinit;
    end
    if (cmd.load_now) begin
      res.accepted       <= cmd.push;
      res.tx_start       <= 1'b0;
      res.tx_id          <= '0;
      res.tx_extended    <= 1'b0;
      res.tx_length      <= '0;
      res.tx_data        <= '0;
      res.reinit_request <= cmd.reinit;
      res.overflow_total <= overflow_next;
    end else if (cmd.load_mem) begin
      res.accepted       <= 1'b0;
      res.tx_start       <= 1'b1;
      res.tx_id          <= rslot.id;
      res.tx_extended    <= rslot.extended;
      res.tx_length      <= rslot.length;
      res.tx_data        <= rslot.data;
      res.reinit_request <= pend_reinit;
      res.overflow_total <= overflow;
    end
  end

  `CTFQ_ASSERT(a_flush_empties, clk, rst, cmd.flush |=> (rd_ptr == wr_ptr), "flush left data")
  `CTFQ_NEVER(a_pop_empty, clk, rst, cmd.pop && status.empty, "pop from empty ring")
  `CTFQ_NEVER(a_push_full, clk, rst, cmd.push && status.full, "push into full ring")

endmodule

// ===== src/ctfq_ctrl.sv =====
// controller: handshake, sender state and command decode
// depends on ctfq_pkg and the assertion macro header
`include "can_tx_frame_queue_assert.svh"

module ctfq_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            command,
  input  logic                  tx_complete,
  input  logic                  bus_off,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  ctfq_pkg::ctl_status_t status,
  output ctfq_pkg::ctl_cmd_t    cmd
);
  import ctfq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   busy;
  logic   busy_next;
  logic   accept;
  logic   is_enq;
  logic   is_svc;

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign is_enq   = (command == CMD_ENQ_STD) || (command == CMD_ENQ_EXT);
  assign is_svc   = (command == CMD_SERVICE);

  assign cmd.push     = accept && is_enq && !status.full;
  assign cmd.flush    = accept && is_enq && status.full;
  assign cmd.pop      = accept && is_svc && !busy && !status.empty;
  assign cmd.reinit   = accept && is_svc && bus_off;
  assign cmd.load_now = accept && !cmd.pop;
  assign cmd.load_mem = (state == ST_READ);

  always_comb begin
    busy_next = busy;
    if (cmd.pop) begin
      busy_next = 1'b1;
    end else if (accept && is_svc && busy && tx_complete) begin
      busy_next = 1'b0;
    end
  end

  always_comb begin
    case (state)
      ST_IDLE: state_next = cmd.pop ? ST_READ : ST_IDLE;
      ST_READ: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= busy_next;
      if (cmd.load_now || cmd.load_mem) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `CTFQ_ASSERT(a_read_one_cycle, clk, rst, state == ST_READ |=> state == ST_IDLE, "read stuck")
  `CTFQ_NEVER(a_read_overwrites, clk, rst, state == ST_READ && out_valid, "result overwritten")
  `CTFQ_ASSERT(a_pop_sets_busy, clk, rst, cmd.pop |=> busy && state == ST_READ, "pop lost")

endmodule

// ===== src/can_tx_frame_queue.sv =====
// top level of the can transmit frame queue: controller plus datapath
// depends on ctfq_pkg, ctfq_stream_if, ctfq_ctrl, ctfq_dp
//
// port      dir  beat type    contents
// request   in   in_item_t    command, frame fields, tx_complete, bus_off
// result    out  out_item_t   accepted, tx frame fields, reinit, overflow count
//
// enqueue and service without a pop load the result register directly; a pop
// first does the registered frame ram read and then loads the result register
// a new request is taken while the last result waits if it is taken that cycle
// synchronous reset clears pointers, overflow count, sender state and valid
// the ram holds no reset and needs no clearing pass
module can_tx_frame_queue #(
  parameter int QUEUE_DEPTH = ctfq_pkg::QUEUE_DEPTH_DEF
) (
  input logic           clk,
  input logic           rst,
  ctfq_stream_if.sink   request,
  ctfq_stream_if.source result
);
  import ctfq_pkg::*;

  ctl_cmd_t    cmd;
  ctl_status_t status;
  in_item_t    item;
  out_item_t   res;

  assign item = request.payload;

  ctfq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (request.valid),
    .in_ready   (request.ready),
    .command    (item.command),
    .tx_complete(item.tx_complete),
    .bus_off    (item.bus_off),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .status     (status),
    .cmd        (cmd)
  );

  ctfq_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .item  (item),
    .status(status),
    .res   (res)
  );

  assign result.payload = res;

endmodule
